// File: design/usb_transfer_sizing_core_macros.svh
// Assertion macros used by the transfer sizing core design file.
`ifndef USB_TRANSFER_SIZING_CORE_MACROS_SVH
`define USB_TRANSFER_SIZING_CORE_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define UTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define UTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/uts_pkg.sv
// Types, codes and lookup tables for the USB transfer sizing block.
package uts_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_BUF,
    ST_DIV_HFS,
    ST_FINISH
  } state_t;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_INVALID     = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd3;

  localparam logic [1:0] EP_CONTROL   = 2'd0;
  localparam logic [1:0] EP_ISOCH     = 2'd1;
  localparam logic [1:0] EP_BULK      = 2'd2;
  localparam logic [1:0] EP_INTERRUPT = 2'd3;

  localparam logic [2:0] SPEED_FULL     = 3'd1;
  localparam logic [2:0] SPEED_HIGH     = 3'd2;
  localparam logic [2:0] SPEED_VARIABLE = 3'd3;

  localparam logic [1:0] CFG_MAX_PACKET_SIZE  = 2'd0;
  localparam logic [1:0] CFG_MAX_PACKET_COUNT = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAME_SIZE   = 2'd2;

  localparam int PSIZE_W   = 11;
  localparam int FSIZE_W   = 12;
  localparam int BUF_W     = 25;
  localparam int DIV_STEPS = 25;
  localparam int CNT_W     = 5;

  localparam logic [15:0] HS_PACKET_MASK = 16'h07FF;
  localparam logic [BUF_W-1:0] SETUP_BYTES = 25'd8;

  // Largest interrupt packet per speed.
  function automatic logic [PSIZE_W-1:0] intr_max(input logic [1:0] spd);
    case (spd)
      2'd0:    intr_max = 11'd8;
      2'd1:    intr_max = 11'd64;
      default: intr_max = 11'd1024;
    endcase
  endfunction

  // Fixed control packet size per speed.
  function automatic logic [PSIZE_W-1:0] ctrl_min(input logic [1:0] spd);
    case (spd)
      2'd0, 2'd1: ctrl_min = 11'd8;
      2'd2:       ctrl_min = 11'd64;
      default:    ctrl_min = 11'd512;
    endcase
  endfunction

  // Fixed bulk packet size per speed.
  function automatic logic [PSIZE_W-1:0] bulk_base(input logic [1:0] spd);
    case (spd)
      2'd0, 2'd1: bulk_base = 11'd8;
      default:    bulk_base = 11'd512;
    endcase
  endfunction

endpackage

// File: design/usb_transfer_sizing_core.sv
// Top level of the USB transfer sizing block with its shared remainder unit.
//
//  Channel   Handshake                 Carries
//  --------  ------------------------  ----------------------------------
//  input     in_valid / in_stall       one endpoint description and request
//  output    out_valid / out_stall     one set of transfer parameters
//  config    cfg_valid / cfg_ready     register index and write data
//
// An item runs from the accept cycle through two passes of 25 steps in one radix-2
// remainder unit (buffer rounding, then host frame limit) to the finish state. An
// item that fails the early checks goes from the accept cycle straight to the
// finish state.
// The input stalls from acceptance until the result is loaded into the output
// register; a stalled output holds the sequencer in its finish state.
// Reset is synchronous, stalls the input and restores the host limits to their defaults.
module usb_transfer_sizing_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  endpoint_type,
  input  logic [2:0]  link_speed,
  input  logic [15:0] raw_max_packet,
  input  logic [7:0]  descriptor_interval,
  input  logic [7:0]  requested_frames,
  input  logic [15:0] requested_interval,
  input  logic [23:0] requested_buffer,
  input  logic        external_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] packet_size,
  output logic [7:0]  packet_count,
  output logic [23:0] frame_size,
  output logic [15:0] poll_interval,
  output logic [4:0]  poll_shift,
  output logic [24:0] buffer_size,
  output logic [24:0] data_length,
  output logic [7:0]  frame_count,
  output logic [23:0] host_frame_size,
  output logic        is_control,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import uts_pkg::*;
  `include "usb_transfer_sizing_core_macros.svh"

  // Host limit registers.
  logic [15:0] hmps;
  logic [7:0]  hmpc;
  logic [23:0] hmfs;

  // Sequencer and remainder unit.
  state_t state, state_next;
  logic [CNT_W-1:0]   cnt;
  logic [BUF_W-1:0]   dvd;
  logic [FSIZE_W-1:0] rem;
  logic [FSIZE_W:0]   trial;
  logic [FSIZE_W:0]   trial_sub;
  logic [FSIZE_W-1:0] rem_step;

  // Item registers.
  logic [1:0]         err;
  logic               ctl;
  logic               ext;
  logic [PSIZE_W-1:0] psize;
  logic [1:0]         pcount;
  logic [FSIZE_W-1:0] fsize;
  logic [15:0]        ival;
  logic [4:0]         shift;
  logic [7:0]         rframes;
  logic [BUF_W-1:0]   buf_orig;
  logic [BUF_W-1:0]   buf_fin;

  // Control strobes.
  logic accept, step_last, load_out;

  // Values formed from the input beat.
  logic [1:0]         e_err;
  logic               e_fast;
  logic               e_intr;
  logic [15:0]        e_raw;
  logic [2:0]         e_cnt_hs;
  logic [1:0]         e_pcount;
  logic [15:0]        e_ps_host;
  logic [PSIZE_W-1:0] e_psize;
  logic [PSIZE_W-1:0] e_base;
  logic [FSIZE_W:0]   e_prod;
  logic [FSIZE_W-1:0] e_fsize;
  logic [15:0]        e_ival;
  logic [15:0]        e_ival_m1;
  logic [4:0]         e_shift;
  logic [3:0]         e_dint_m4;
  logic [BUF_W-1:0]   e_buf;

  // Values formed at the finish.
  logic [BUF_W-1:0] f_hfs;
  logic [7:0]       f_frames;
  logic [1:0]       f_status;

  assign cfg_ready = 1'b1;

  // Host limit register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      hmps <= 16'd1024;
      hmpc <= 8'd3;
      hmfs <= 24'd20480;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_PACKET_SIZE:  hmps <= cfg_data[15:0];
        CFG_MAX_PACKET_COUNT: hmpc <= cfg_data[7:0];
        CFG_MAX_FRAME_SIZE:   hmfs <= cfg_data;
        default: ;
      endcase
    end
  end

  // Error classification of the incoming beat.
  always_comb begin
    if (hmps == 16'd0 || hmpc == 8'd0 || hmfs == 24'd0) begin
      e_err = STATUS_INVALID;
    end else if (link_speed > SPEED_VARIABLE || endpoint_type == EP_ISOCH) begin
      e_err = STATUS_UNSUPPORTED;
    end else begin
      e_err = STATUS_OK;
    end
  end

  assign e_fast = (link_speed == SPEED_HIGH) || (link_speed == SPEED_VARIABLE);
  assign e_intr = (endpoint_type == EP_INTERRUPT);

  // Packet count from the high-speed multiplier, clamped to the host.
  always_comb begin
    e_cnt_hs = 3'd1;
    if (link_speed == SPEED_HIGH && e_intr) begin
      e_cnt_hs = 3'd1 + {1'b0, raw_max_packet[12:11]};
      if (e_cnt_hs > 3'd3) begin
        e_cnt_hs = 3'd3;
      end
    end
    if ({5'd0, e_cnt_hs} > hmpc) begin
      e_pcount = hmpc[1:0];
    end else begin
      e_pcount = e_cnt_hs[1:0];
    end
  end

  // Packet size clamped to the host and then to the speed tables.
  always_comb begin
    e_raw = (link_speed == SPEED_HIGH) ? (raw_max_packet & HS_PACKET_MASK) : raw_max_packet;
    e_ps_host = (e_raw > hmps || e_raw == 16'd0) ? hmps : e_raw;
    e_base = (endpoint_type == EP_BULK) ? bulk_base(link_speed[1:0])
                                        : ctrl_min(link_speed[1:0]);
    if (e_intr) begin
      if (e_ps_host > {5'd0, intr_max(link_speed[1:0])}) begin
        e_psize = intr_max(link_speed[1:0]);
      end else begin
        e_psize = e_ps_host[PSIZE_W-1:0];
      end
    end else if (link_speed == SPEED_FULL) begin
      if (e_ps_host >= 16'd64) begin
        e_psize = 11'd64;
      end else if (e_ps_host >= 16'd32) begin
        e_psize = 11'd32;
      end else if (e_ps_host >= 16'd16) begin
        e_psize = 11'd16;
      end else begin
        e_psize = e_base;
      end
    end else begin
      e_psize = e_base;
    end
  end

  assign e_prod  = {2'd0, e_psize} * {11'd0, e_pcount};
  assign e_fsize = e_prod[FSIZE_W-1:0];

  // Polling interval in milliseconds and its ceiling log2 (plus 3 on fast links).
  always_comb begin
    e_dint_m4 = 4'(descriptor_interval - 8'd4);
    e_ival = requested_interval;
    if (e_intr) begin
      if (requested_interval == 16'd0) begin
        e_ival = {8'd0, descriptor_interval};
        if (e_fast) begin
          if (descriptor_interval < 8'd4) begin
            e_ival = 16'd1;
          end else if (descriptor_interval > 8'd16) begin
            e_ival = 16'd4096;
          end else begin
            e_ival = 16'd1 << e_dint_m4;
          end
        end
      end
      if (e_ival == 16'd0) begin
        e_ival = 16'd1;
      end
    end
  end

  always_comb begin
    e_ival_m1 = e_ival - 16'd1;
    e_shift = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (e_ival_m1[i]) begin
        e_shift = 5'(i + 1);
      end
    end
    if (!e_intr) begin
      e_shift = 5'd0;
    end else if (e_fast) begin
      e_shift = e_shift + 5'd3;
    end
  end

  // Buffer before rounding, with the frame minus one added when rounding up.
  always_comb begin
    e_buf = (requested_buffer == 24'd0) ? {13'd0, e_fsize} : {1'b0, requested_buffer};
    if (external_buffer) begin
      e_buf = e_buf + {13'd0, e_fsize} - 25'd1;
    end
  end

  // One radix-2 remainder step.
  assign trial     = {rem, dvd[BUF_W-1]};
  assign trial_sub = trial - {1'b0, fsize};
  assign rem_step  = trial_sub[FSIZE_W] ? trial[FSIZE_W-1:0] : trial_sub[FSIZE_W-1:0];
  assign step_last = (cnt == CNT_W'(DIV_STEPS - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (e_err != STATUS_OK) ? ST_FINISH : ST_DIV_BUF;
        end
      end
      ST_DIV_BUF: begin
        if (step_last) begin
          state_next = ST_DIV_HFS;
        end
      end
      ST_DIV_HFS: begin
        if (step_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = rst || (state != ST_IDLE);
    accept   = !rst && (state == ST_IDLE) && in_valid;
    load_out = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Rounded buffer: take off the remainder when rounding up, then add the setup bytes for a control endpoint.
  function automatic logic [BUF_W-1:0] buf_fin_calc(input logic x, input logic c,
                                                    input logic [BUF_W-1:0] orig,
                                                    input logic [FSIZE_W-1:0] r);
    logic [BUF_W-1:0] b;
    b = orig;
    if (x) begin
      b = b - {13'd0, r};
      if (c) begin
        b = b + SETUP_BYTES;
      end
    end
    buf_fin_calc = b;
  endfunction

  // Item capture and the remainder unit.
  always_ff @(posedge clk) begin
    if (accept) begin
      err      <= e_err;
      ctl      <= (endpoint_type == EP_CONTROL);
      ext      <= external_buffer;
      psize    <= e_psize;
      pcount   <= e_pcount;
      fsize    <= e_fsize;
      ival     <= e_ival;
      shift    <= e_shift;
      rframes  <= requested_frames;
      buf_orig <= e_buf;
      dvd      <= e_buf;
      rem      <= '0;
      cnt      <= '0;
    end else if (state == ST_DIV_BUF && step_last) begin
      // Keep the rounded buffer and start on the host frame limit.
      buf_fin <= buf_fin_calc(ext, ctl, buf_orig, rem_step);
      dvd     <= {1'b0, hmfs};
      rem     <= '0;
      cnt     <= '0;
    end else if (state == ST_DIV_BUF || state == ST_DIV_HFS) begin
      rem <= rem_step;
      dvd <= {dvd[BUF_W-2:0], 1'b0};
      cnt <= step_last ? '0 : cnt + CNT_W'(1);
    end
  end

  // Final status and frame count.
  always_comb begin
    f_hfs = {1'b0, hmfs} - {13'd0, rem};
    if (ctl) begin
      if (rframes != 8'd0) begin
        f_frames = rframes;
      end else begin
        f_frames = (buf_fin <= SETUP_BYTES) ? 8'd1 : 8'd2;
      end
    end else begin
      f_frames = (rframes != 8'd0) ? rframes : 8'd1;
    end
    if (err != STATUS_OK) begin
      f_status = err;
    end else if (ctl && buf_fin < SETUP_BYTES) begin
      f_status = STATUS_INVALID;
    end else if (f_hfs == '0) begin
      f_status = STATUS_INVALID;
    end else begin
      f_status = STATUS_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status     <= f_status;
      is_control <= ctl;
      if (f_status != STATUS_OK) begin
        packet_size     <= 16'd1;
        packet_count    <= 8'd1;
        frame_size      <= 24'd1;
        poll_interval   <= 16'd0;
        poll_shift      <= 5'd0;
        buffer_size     <= '0;
        data_length     <= '0;
        frame_count     <= 8'd0;
        host_frame_size <= 24'd1;
      end else begin
        packet_size     <= {5'd0, psize};
        packet_count    <= {6'd0, pcount};
        frame_size      <= {12'd0, fsize};
        poll_interval   <= ival;
        poll_shift      <= shift;
        buffer_size     <= buf_fin;
        data_length     <= ctl ? (buf_fin - SETUP_BYTES) : buf_fin;
        frame_count     <= f_frames;
        host_frame_size <= f_hfs[23:0];
      end
    end
  end

  `UTS_ASSERT_IMPL(a_rem_below_frame, (state == ST_DIV_BUF || state == ST_DIV_HFS),
    (rem < fsize), "remainder reached the frame size")
  `UTS_ASSERT_IMPL(a_result_from_finish, $rose(out_valid),
    ($past(state) == ST_FINISH), "result appeared outside the finish state")
  `UTS_ASSERT_IMPL(a_ok_nonzero, (load_out && f_status == STATUS_OK),
    (f_frames != 8'd0 && f_hfs != '0 && fsize != '0), "ok result with a zero count")
  `UTS_ASSERT_NEXT(a_accept_starts, (accept && e_err == STATUS_OK),
    (state == ST_DIV_BUF && cnt == '0), "accepted item did not start the divider")
  `UTS_ASSERT_IMPL(a_buf_source, (state == ST_DIV_BUF && cnt == '0),
    (dvd == buf_orig), "divider did not start from the captured buffer")

endmodule

// File: tb/tb_usb_transfer_sizing_core.sv
// Self-checking testbench for the USB transfer sizing block.
`timescale 1ns / 1ps

module tb_usb_transfer_sizing_core;
  import uts_pkg::*;

  localparam int SPEED_LOW_C   = 0;
  localparam int SPEED_SUPER_C = 4;

  typedef struct packed {
    logic [1:0]  ep_type;
    logic [2:0]  speed;
    logic [15:0] raw_mps;
    logic [7:0]  dint;
    logic [7:0]  rframes;
    logic [15:0] rint;
    logic [23:0] rbuf;
    logic        ext;
  } endpoint_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] psize;
    logic [7:0]  pcount;
    logic [23:0] fsize;
    logic [15:0] ival;
    logic [4:0]  shift;
    logic [24:0] buf_size;
    logic [24:0] dlen;
    logic [7:0]  frames;
    logic [23:0] hfs;
    logic        ctl;
  } sizing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0]  endpoint_type = '0;
  logic [2:0]  link_speed = '0;
  logic [15:0] raw_max_packet = '0;
  logic [7:0]  descriptor_interval = '0;
  logic [7:0]  requested_frames = '0;
  logic [15:0] requested_interval = '0;
  logic [23:0] requested_buffer = '0;
  logic        external_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] packet_size;
  logic [7:0]  packet_count;
  logic [23:0] frame_size;
  logic [15:0] poll_interval;
  logic [4:0]  poll_shift;
  logic [24:0] buffer_size;
  logic [24:0] data_length;
  logic [7:0]  frame_count;
  logic [23:0] host_frame_size;
  logic        is_control;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  usb_transfer_sizing_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Host limits as the predictor sees them.
  logic [15:0] lim_psize;
  logic [7:0]  lim_pcount;
  logic [23:0] lim_fsize;

  sizing_t pending_sizing[$];
  int      errors = 0;
  int      n_sent = 0;
  int      n_seen = 0;
  int      stall_left = 0;
  bit      quiet = 1'b0;

  function automatic sizing_t sizing_error(logic [1:0] code, logic ctl);
    sizing_t r;
    r = '{status: code, psize: 16'd1, pcount: 8'd1, fsize: 24'd1, ival: '0, shift: '0,
          buf_size: '0, dlen: '0, frames: '0, hfs: 24'd1, ctl: ctl};
    return r;
  endfunction

  // Works out the transfer parameters for one endpoint request.
  function automatic sizing_t size_transfer(endpoint_req_t q);
    sizing_t r;
    logic ctl;
    int unsigned ps, pc, fs, iv, sh, bf, dl, fr, hf, base, imax;
    bit fast;
    ctl = (q.ep_type == EP_CONTROL);
    if (lim_psize == 0 || lim_pcount == 0 || lim_fsize == 0)
      return sizing_error(STATUS_INVALID, ctl);
    if (q.speed > SPEED_VARIABLE || q.ep_type == EP_ISOCH)
      return sizing_error(STATUS_UNSUPPORTED, ctl);
    fast = (q.speed == SPEED_HIGH || q.speed == SPEED_VARIABLE);
    ps = q.raw_mps;
    pc = 1;
    if (q.speed == SPEED_HIGH) begin
      if (q.ep_type == EP_INTERRUPT) begin
        pc += q.raw_mps[12:11];
        if (pc > 3) pc = 3;
      end
      ps &= 32'h7FF;
    end
    if (pc > lim_pcount) pc = lim_pcount;
    if (ps > lim_psize || ps == 0) ps = lim_psize;
    if (q.ep_type == EP_INTERRUPT) begin
      imax = (q.speed == SPEED_LOW_C) ? 8 : (q.speed == SPEED_FULL) ? 64 : 1024;
      if (ps > imax) ps = imax;
    end else begin
      if (q.ep_type == EP_BULK)
        base = (q.speed < SPEED_HIGH) ? 8 : 512;
      else
        base = (q.speed < SPEED_HIGH) ? 8 : (q.speed == SPEED_HIGH) ? 64 : 512;
      if (q.speed == SPEED_FULL)
        ps = (ps >= 64) ? 64 : (ps >= 32) ? 32 : (ps >= 16) ? 16 : base;
      else
        ps = base;
    end
    fs = ps * pc;
    // Interval and frame shift, interrupt endpoints only.
    iv = q.rint;
    sh = 0;
    if (q.ep_type == EP_INTERRUPT) begin
      if (iv == 0) begin
        iv = q.dint;
        if (fast)
          iv = (iv < 4) ? 1 : (iv > 16) ? 4096 : (1 << (iv - 4));
      end
      if (iv == 0) iv = 1;
      while ((1 << sh) < iv) sh++;
      if (fast) sh += 3;
    end
    bf = q.rbuf;
    if (bf == 0) bf = fs;
    if (q.ext) begin
      bf += fs - 1;
      bf -= bf % fs;
      if (q.ep_type == EP_CONTROL) bf += 8;
    end
    dl = bf;
    if (q.ep_type == EP_CONTROL) begin
      fr = q.rframes;
      if (fr == 0) fr = (bf <= 8) ? 1 : 2;
      if (dl < 8) return sizing_error(STATUS_INVALID, ctl);
      dl -= 8;
    end else begin
      fr = q.rframes ? q.rframes : 1;
    end
    hf = lim_fsize - (lim_fsize % fs);
    if (hf == 0) return sizing_error(STATUS_INVALID, ctl);
    r = '{status: STATUS_OK, psize: ps[15:0], pcount: pc[7:0], fsize: fs[23:0],
          ival: iv[15:0], shift: sh[4:0], buf_size: bf[24:0], dlen: dl[24:0],
          frames: fr[7:0], hfs: hf[23:0], ctl: ctl};
    return r;
  endfunction

  task automatic write_limit(logic [1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAX_PACKET_SIZE:  lim_psize  = val[15:0];
      CFG_MAX_PACKET_COUNT: lim_pcount = val[7:0];
      default:              lim_fsize  = val;
    endcase
  endtask

  // Presents one request beat; a known result may be given to override the predictor.
  // Valid stays up after the beat so that the next request can follow without a gap.
  task automatic send_request(endpoint_req_t q, bit known, sizing_t want);
    sizing_t p;
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    p = size_transfer(q);
    if (known && p != want) begin
      $error("predictor disagrees with table row %0d", n_sent);
      errors++;
    end
    pending_sizing.push_back(known ? want : p);
    {endpoint_type, link_speed, raw_max_packet, descriptor_interval, requested_frames,
     requested_interval, requested_buffer, external_buffer} <= q;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_sizing.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic endpoint_req_t random_request();
    endpoint_req_t q;
    q = $bits(endpoint_req_t)'({$urandom, $urandom, $urandom});
    q.ep_type = ($urandom_range(9) == 0) ? EP_ISOCH
              : ($urandom_range(2) == 0) ? EP_CONTROL
              : ($urandom_range(1) ? EP_BULK : EP_INTERRUPT);
    q.speed = ($urandom_range(15) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
    if ($urandom_range(1)) q.rint = 16'($urandom_range(40));
    if ($urandom_range(1)) q.dint = 8'($urandom_range(20));
    if ($urandom_range(2) == 0) q.rbuf = 24'($urandom_range(20));
    else if ($urandom_range(1)) q.rbuf = 24'($urandom_range(5000));
    if ($urandom_range(3) == 0) q.raw_mps = 16'($urandom_range(70));
    return q;
  endfunction

  // Output side: random stall bursts and checking against the oldest prediction.
  always @(posedge clk) begin
    sizing_t e, a;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        a = '{status, packet_size, packet_count, frame_size, poll_interval, poll_shift,
              buffer_size, data_length, frame_count, host_frame_size, is_control};
        if (pending_sizing.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = pending_sizing.pop_front();
          n_seen++;
          if (a != e) begin
            errors++;
            if (a.status != e.status) $error("status exp %0d got %0d", e.status, a.status);
            if (a.psize != e.psize) $error("packet_size exp %0d got %0d", e.psize, a.psize);
            if (a.pcount != e.pcount)
              $error("packet_count exp %0d got %0d", e.pcount, a.pcount);
            if (a.fsize != e.fsize) $error("frame_size exp %0d got %0d", e.fsize, a.fsize);
            if (a.ival != e.ival) $error("poll_interval exp %0d got %0d", e.ival, a.ival);
            if (a.shift != e.shift) $error("poll_shift exp %0d got %0d", e.shift, a.shift);
            if (a.buf_size != e.buf_size)
              $error("buffer_size exp %0d got %0d", e.buf_size, a.buf_size);
            if (a.dlen != e.dlen) $error("data_length exp %0d got %0d", e.dlen, a.dlen);
            if (a.frames != e.frames)
              $error("frame_count exp %0d got %0d", e.frames, a.frames);
            if (a.hfs != e.hfs) $error("host_frame_size exp %0d got %0d", e.hfs, a.hfs);
            if (a.ctl != e.ctl) $error("is_control exp %0d got %0d", e.ctl, a.ctl);
          end
        end
      end
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else if (!out_stall && $urandom_range(4) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Directed rows: request, whether a result is typed in, and that result.
  endpoint_req_t dir_req[20];
  bit            dir_known[20];
  sizing_t       dir_want[20];

  initial begin
    endpoint_req_t q;
    sizing_t ok_bulk;
    lim_psize = 16'd1024;
    lim_pcount = 8'd3;
    lim_fsize = 24'd20480;
    ok_bulk = '{status: STATUS_OK, psize: 16'd512, pcount: 8'd1, fsize: 24'd512, ival: '0,
                shift: '0, buf_size: 25'd512, dlen: 25'd512, frames: 8'd1,
                hfs: 24'd20480, ctl: 1'b0};
    // Rows: isochronous, super speed, top speed code, short control buffer, bulk at
    // reset limits, then extremes of the interrupt, control and bulk kinds checked by the predictor.
    dir_req[0] = '{EP_ISOCH, SPEED_FULL, 16'd64, 8'd1, 8'd0, 16'd0, 24'd0, 1'b0};
    dir_req[1] = '{EP_BULK, 3'(SPEED_SUPER_C), 16'd64, 8'd1, 8'd0, 16'd0, 24'd0, 1'b0};
    dir_req[2] = '{EP_CONTROL, 3'd7, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 24'hFFFFFF, 1'b1};
    dir_req[3] = '{EP_CONTROL, 3'(SPEED_LOW_C), 16'd8, 8'd0, 8'd0, 16'd0, 24'd5, 1'b0};
    dir_req[4] = '{EP_BULK, SPEED_HIGH, 16'd512, 8'd0, 8'd0, 16'd0, 24'd0, 1'b0};
    dir_req[5] = '{EP_INTERRUPT, SPEED_HIGH, 16'hFFFF, 8'hFF, 8'hFF, 16'd0, 24'hFFFFFF, 1'b1};
    dir_req[6] = '{EP_INTERRUPT, SPEED_HIGH, 16'h1C00, 8'd17, 8'd0, 16'd0, 24'd0, 1'b0};
    dir_req[7] = '{EP_INTERRUPT, SPEED_VARIABLE, 16'd0, 8'd3, 8'd0, 16'd0, 24'd1, 1'b1};
    dir_req[8] = '{EP_INTERRUPT, SPEED_VARIABLE, 16'd100, 8'd10, 8'd4, 16'd0, 24'd7, 1'b0};
    dir_req[9] = '{EP_INTERRUPT, 3'(SPEED_LOW_C), 16'd0, 8'd0, 8'd0, 16'd0, 24'd0, 1'b1};
    dir_req[10] = '{EP_INTERRUPT, SPEED_FULL, 16'd200, 8'd255, 8'd0, 16'hFFFF, 24'd0, 1'b0};
    dir_req[11] = '{EP_CONTROL, SPEED_FULL, 16'd40, 8'd0, 8'd0, 16'd9, 24'd0, 1'b1};
    dir_req[12] = '{EP_CONTROL, SPEED_FULL, 16'd20, 8'd0, 8'd0, 16'd0, 24'd9, 1'b0};
    dir_req[13] = '{EP_CONTROL, SPEED_FULL, 16'd7, 8'd0, 8'd0, 16'd0, 24'd0, 1'b0};
    dir_req[14] = '{EP_CONTROL, SPEED_HIGH, 16'd64, 8'd0, 8'd0, 16'd0, 24'hFFFFFF, 1'b1};
    dir_req[15] = '{EP_CONTROL, SPEED_VARIABLE, 16'd0, 8'd0, 8'd3, 16'd0, 24'd1000, 1'b1};
    dir_req[16] = '{EP_BULK, SPEED_FULL, 16'd65, 8'd0, 8'd0, 16'd0, 24'd100, 1'b1};
    dir_req[17] = '{EP_BULK, 3'(SPEED_LOW_C), 16'd1, 8'd0, 8'd255, 16'd5, 24'd0, 1'b0};
    dir_req[18] = '{EP_BULK, SPEED_VARIABLE, 16'hFFFF, 8'd0, 8'd0, 16'd0, 24'hFFFFFF, 1'b1};
    dir_req[19] = '{EP_INTERRUPT, SPEED_HIGH, 16'h0800, 8'd4, 8'd1, 16'd0, 24'd0, 1'b0};
    foreach (dir_known[i]) dir_known[i] = 1'b0;
    dir_known[0:4] = '{1, 1, 1, 1, 1};
    dir_want[0] = sizing_error(STATUS_UNSUPPORTED, 1'b0);
    dir_want[1] = sizing_error(STATUS_UNSUPPORTED, 1'b0);
    dir_want[2] = sizing_error(STATUS_UNSUPPORTED, 1'b1);
    dir_want[3] = sizing_error(STATUS_INVALID, 1'b1);
    dir_want[4] = ok_bulk;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 20; i++) send_request(dir_req[i], dir_known[i], dir_want[i]);
    drain();

    // Random phases under several host limit settings, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_limit(CFG_MAX_PACKET_SIZE, 24'd0);
          q = random_request();
          send_request(q, 1'b1, sizing_error(STATUS_INVALID, q.ep_type == EP_CONTROL));
          drain();
          write_limit(CFG_MAX_PACKET_SIZE, 24'hFFFF);
          write_limit(CFG_MAX_PACKET_COUNT, 24'hFF);
          write_limit(CFG_MAX_FRAME_SIZE, 24'hFFFFFF);
        end
        1: begin
          write_limit(CFG_MAX_PACKET_COUNT, 24'd0);
          q = random_request();
          send_request(q, 1'b1, sizing_error(STATUS_INVALID, q.ep_type == EP_CONTROL));
          drain();
          write_limit(CFG_MAX_FRAME_SIZE, 24'd0);
          q = random_request();
          send_request(q, 1'b1, sizing_error(STATUS_INVALID, q.ep_type == EP_CONTROL));
          drain();
          write_limit(CFG_MAX_PACKET_SIZE, 24'd1);
          write_limit(CFG_MAX_PACKET_COUNT, 24'd1);
          write_limit(CFG_MAX_FRAME_SIZE, 24'd1);
        end
        2: begin
          write_limit(CFG_MAX_PACKET_SIZE, 24'd600);
          write_limit(CFG_MAX_PACKET_COUNT, 24'd2);
          write_limit(CFG_MAX_FRAME_SIZE, 24'd700);
        end
        7: quiet = 1'b1;
        default: begin
          write_limit(CFG_MAX_PACKET_SIZE, 24'($urandom_range(1, 65535)));
          write_limit(CFG_MAX_PACKET_COUNT, 24'($urandom_range(1, 255)));
          write_limit(CFG_MAX_FRAME_SIZE, 24'($urandom_range(1, 24'hFFFFFF)));
        end
      endcase
      repeat (105) send_request(random_request(), 1'b0, '0);
      drain();
    end

    $display("Sent %0d endpoint requests, checked %0d results over eight limit settings.",
             n_sent, n_seen);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/uts_pkg.sv
design/usb_transfer_sizing_core.sv
tb/tb_usb_transfer_sizing_core.sv
